### hw/rtl/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

  // Record geometry of a champion file.
  localparam int NAME_BYTES    = 128;
  localparam int COMMENT_BYTES = 2048;
  localparam int CODE_LIMIT    = 1024;
  localparam int PAD_LEN       = 4;
  localparam int WORD_LEN      = 4;

  // Field widths.
  localparam int COUNT_W  = 12;
  localparam int OFFSET_W = 11;
  localparam int SIZE_W   = 11;
  localparam int WORD_W   = 32;

  // Configuration registers.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SIZE = 1'b1;
  localparam logic [WORD_W-1:0] MAGIC_RESET    = 32'd15369203;
  localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 11'd682;

  // Queue between the parser and the result formatter.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // Input item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  typedef enum logic [1:0] {
    RK_NAME    = 2'd0,
    RK_COMMENT = 2'd1,
    RK_CODE    = 2'd2,
    RK_STATUS  = 2'd3
  } rkind_t;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_MAGIC         = 4'd1,
    ST_SHORT_MAGIC   = 4'd2,
    ST_SHORT_NAME    = 4'd3,
    ST_NAME_PAD      = 4'd4,
    ST_SHORT_SIZE    = 4'd5,
    ST_ZERO_SIZE     = 4'd6,
    ST_TOO_BIG       = 4'd7,
    ST_SHORT_COMMENT = 4'd8,
    ST_COMMENT_PAD   = 4'd9,
    ST_SHORT_CODE    = 4'd10,
    ST_TRAILING      = 4'd11
  } status_t;

  // Compact result record. For byte results arg is the offset and data the
  // byte; for a status arg is the code size and data holds {name_empty, status}.
  typedef struct packed {
    rkind_t              rk;
    logic [OFFSET_W-1:0] arg;
    logic [7:0]          data;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/cfp_item_if.sv
`default_nettype none

interface cfp_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/cfp_result_if.sv
`default_nettype none

interface cfp_result_if import cfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          result_kind;
  logic [OFFSET_W-1:0] offset;
  logic [7:0]          out_byte;
  logic [3:0]          status;
  logic                name_empty;
  logic [SIZE_W-1:0]   code_size;

  modport source (output valid, output result_kind, output offset, output out_byte,
                  output status, output name_empty, output code_size, input ready);
  modport sink (input valid, input result_kind, input offset, input out_byte,
                input status, input name_empty, input code_size, output ready);
endinterface

`default_nettype wire

### hw/rtl/champion_file_parser_top.sv
// Champion file parser: one byte or end-of-file transaction per cycle while the
// queue has room. An accepted transaction is written into the queue and then
// into the result register; the four-entry queue lets the parser keep accepting
// while the result register is stalled, until the queue fills.
// Reset (rst, synchronous) returns the parser to the magic field, empties the
// queue and loads the reset values of the magic word and size limit.
`default_nettype none

module champion_file_parser_top import cfp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wen,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  cfp_item_if.sink                    items,
  cfp_result_if.source                results
);

  cmd_t push_data;
  cmd_t pop_data;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;

  // Parser: accepts and classifies bytes.
  cfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .items      (items),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Queue between parser and formatter.
  cfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  // Formatter: drives the result register.
  cfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_data    (pop_data),
    .queue_empty (queue_empty),
    .pop         (pop),
    .results     (results)
  );

endmodule

`default_nettype wire

### hw/rtl/cfp_queue.sv
`default_nettype none

module cfp_queue import cfp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign full     = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Storage writes need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cfp_front.sv
`default_nettype none

module cfp_front import cfp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wen,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  cfp_item_if.sink                    items,
  input  wire logic                   queue_full,
  output logic                        push,
  output cmd_t                        push_data
);

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_NAME    = 3'd1,
    PH_NPAD    = 3'd2,
    PH_SIZE    = 3'd3,
    PH_COMMENT = 3'd4,
    PH_CPAD    = 3'd5,
    PH_CODE    = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  logic [WORD_W-1:0]  magic_value;
  logic [SIZE_W-1:0]  max_code_size;

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [WORD_W-1:0]  word_accum, word_accum_next;
  logic [WORD_W-1:0]  declared_size, declared_size_next;
  logic               empty_name_flag, empty_name_flag_next;
  logic               error_seen, error_seen_next;

  logic               accept;
  logic               emit;
  cmd_t               cmd;
  logic [COUNT_W-1:0] count_inc;
  logic [WORD_W-1:0]  accum_shift;
  logic [WORD_W-1:0]  size_limit;
  logic [7:0]         b;

  assign items.ready = !queue_full && !rst;
  assign accept      = items.valid && items.ready;
  assign push        = accept && emit;
  assign push_data   = cmd;

  assign b           = items.data_byte;
  assign count_inc   = byte_count + 1'b1;
  assign accum_shift = {word_accum[WORD_W-9:0], b};
  assign size_limit  = (max_code_size < SIZE_W'(CODE_LIMIT)) ?
                       WORD_W'(max_code_size) : WORD_W'(CODE_LIMIT);

  // Classify the item against the current field of the file.
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    word_accum_next      = word_accum;
    declared_size_next   = declared_size;
    empty_name_flag_next = empty_name_flag;
    error_seen_next      = error_seen;
    emit                 = 1'b0;
    cmd                  = '{rk: RK_STATUS, arg: '0, data: '0};

    if (items.kind == KIND_EOF) begin
      // End of file reports once and then restarts for the next file.
      if (!error_seen) begin
        emit = 1'b1;
        unique case (phase)
          PH_MAGIC:   cmd.data = {4'd0, ST_SHORT_MAGIC};
          PH_NAME:    cmd.data = {4'd0, ST_SHORT_NAME};
          PH_NPAD:    cmd.data = {4'd0, ST_NAME_PAD};
          PH_SIZE:    cmd.data = {4'd0, ST_SHORT_SIZE};
          PH_COMMENT: cmd.data = {4'd0, ST_SHORT_COMMENT};
          PH_CPAD:    cmd.data = {4'd0, ST_COMMENT_PAD};
          PH_CODE:    cmd.data = {4'd0, ST_SHORT_CODE};
          PH_DONE: begin
            cmd.data = {3'd0, empty_name_flag, ST_OK};
            cmd.arg  = declared_size[OFFSET_W-1:0];
          end
        endcase
      end
      phase_next           = PH_MAGIC;
      byte_count_next      = '0;
      word_accum_next      = '0;
      declared_size_next   = '0;
      empty_name_flag_next = 1'b0;
      error_seen_next      = 1'b0;
    end else if (!error_seen) begin
      unique case (phase)
        PH_MAGIC: begin
          word_accum_next = accum_shift;
          byte_count_next = count_inc;
          if (count_inc >= COUNT_W'(WORD_LEN)) begin
            if (accum_shift != magic_value) begin
              emit            = 1'b1;
              cmd.data        = {4'd0, ST_MAGIC};
              error_seen_next = 1'b1;
            end else begin
              phase_next      = PH_NAME;
              byte_count_next = '0;
            end
          end
        end
        PH_NAME: begin
          emit     = 1'b1;
          cmd.rk   = RK_NAME;
          cmd.arg  = byte_count[OFFSET_W-1:0];
          cmd.data = b;
          if (byte_count == '0) begin
            empty_name_flag_next = (b == 8'd0);
          end
          byte_count_next = count_inc;
          if (count_inc >= COUNT_W'(NAME_BYTES)) begin
            phase_next      = PH_NPAD;
            byte_count_next = '0;
          end
        end
        PH_NPAD: begin
          if (b != 8'd0) begin
            emit            = 1'b1;
            cmd.data        = {4'd0, ST_NAME_PAD};
            error_seen_next = 1'b1;
          end else begin
            byte_count_next = count_inc;
            if (count_inc >= COUNT_W'(PAD_LEN)) begin
              phase_next      = PH_SIZE;
              byte_count_next = '0;
              word_accum_next = '0;
            end
          end
        end
        PH_SIZE: begin
          word_accum_next = accum_shift;
          byte_count_next = count_inc;
          if (count_inc >= COUNT_W'(WORD_LEN)) begin
            declared_size_next = accum_shift;
            if (accum_shift == '0) begin
              emit            = 1'b1;
              cmd.data        = {4'd0, ST_ZERO_SIZE};
              error_seen_next = 1'b1;
            end else begin
              phase_next      = PH_COMMENT;
              byte_count_next = '0;
            end
          end
        end
        PH_COMMENT: begin
          emit            = 1'b1;
          cmd.rk          = RK_COMMENT;
          cmd.arg         = byte_count[OFFSET_W-1:0];
          cmd.data        = b;
          byte_count_next = count_inc;
          if (count_inc >= COUNT_W'(COMMENT_BYTES)) begin
            phase_next      = PH_CPAD;
            byte_count_next = '0;
          end
        end
        PH_CPAD: begin
          if (b != 8'd0) begin
            emit            = 1'b1;
            cmd.data        = {4'd0, ST_COMMENT_PAD};
            error_seen_next = 1'b1;
          end else begin
            byte_count_next = count_inc;
            if (count_inc >= COUNT_W'(PAD_LEN)) begin
              // The size limit is checked once the comment pad is complete.
              if (declared_size > size_limit) begin
                emit            = 1'b1;
                cmd.data        = {4'd0, ST_TOO_BIG};
                error_seen_next = 1'b1;
              end else begin
                phase_next      = PH_CODE;
                byte_count_next = '0;
              end
            end
          end
        end
        PH_CODE: begin
          emit            = 1'b1;
          cmd.rk          = RK_CODE;
          cmd.arg         = byte_count[OFFSET_W-1:0];
          cmd.data        = b;
          byte_count_next = count_inc;
          if (WORD_W'(count_inc) >= declared_size) begin
            phase_next      = PH_DONE;
            byte_count_next = '0;
          end
        end
        PH_DONE: begin
          emit            = 1'b1;
          cmd.data        = {4'd0, ST_TRAILING};
          error_seen_next = 1'b1;
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value   <= MAGIC_RESET;
      max_code_size <= MAX_SIZE_RESET;
    end else if (cfg_wen) begin
      if (cfg_index == CFG_MAGIC) begin
        magic_value <= cfg_data;
      end else if (cfg_index == CFG_MAX_SIZE) begin
        max_code_size <= cfg_data[SIZE_W-1:0];
      end
    end
  end

  // Parser state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC;
      byte_count      <= '0;
      word_accum      <= '0;
      declared_size   <= '0;
      empty_name_flag <= 1'b0;
      error_seen      <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      word_accum      <= word_accum_next;
      declared_size   <= declared_size_next;
      empty_name_flag <= empty_name_flag_next;
      error_seen      <= error_seen_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cfp_back.sv
`default_nettype none

module cfp_back import cfp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      pop_data,
  input  wire logic queue_empty,
  output logic      pop,
  cfp_result_if.source results
);

  logic                out_valid;
  rkind_t              out_kind;
  logic [OFFSET_W-1:0] out_offset;
  logic [7:0]          out_data;
  status_t             out_status;
  logic                out_empty;
  logic [SIZE_W-1:0]   out_size;

  assign pop = !queue_empty && (!out_valid || results.ready);

  assign results.valid       = out_valid;
  assign results.result_kind = out_kind;
  assign results.offset      = out_offset;
  assign results.out_byte    = out_data;
  assign results.status      = out_status;
  assign results.name_empty  = out_empty;
  assign results.code_size   = out_size;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Unpack the queued record into the result fields, zeroing unused ones.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind <= pop_data.rk;
      if (pop_data.rk == RK_STATUS) begin
        out_offset <= '0;
        out_data   <= '0;
        out_status <= status_t'(pop_data.data[3:0]);
        out_empty  <= pop_data.data[4];
        out_size   <= pop_data.arg;
      end else begin
        out_offset <= pop_data.arg;
        out_data   <= pop_data.data;
        out_status <= ST_OK;
        out_empty  <= 1'b0;
        out_size   <= '0;
      end
    end
  end

endmodule

`default_nettype wire
